FILE: rtl/core/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

    localparam int NUM_FRAMES_DEF = 4096;
    localparam int FRAME_W        = 12;
    localparam int ACT_W          = 2;
    localparam int STAT_W         = 2;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_QUERY   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_SKIP = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // lowest clear bit of a bitmap word
    function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W:0] res;
        res = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                res = {1'b1, BIT_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/fba_ram.sv
`timescale 1ns / 1ps

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// First-fit page frame allocator over a bitmap of 32 frames per word.
// Request channel: i_in_valid / o_in_stall with action, page_frame and the
// kernel and writable page flags. Response channel: o_out_valid / i_out_stall
// with status, new_frame, present/rw/user bits and in_use. One response per request.
// Steps from accept to response valid:
//   allocate with nonzero frame, release of frame zero, undefined action, and
//   release or query out of range: straight to the finish state
//   release and query: bitmap read, then write-back or answer, then finish
//   allocate with frame zero: scan from word 0 to the first free frame, else FULL
// The scan reads the bitmap RAM one word per cycle through one lowest-clear-bit
// finder. One request is in flight at a time; o_in_stall is high until it is
// done, so a new request is accepted only after the last one has finished.
// A finished response waits in the output register
// while the receiver stalls, and the next request is accepted meanwhile; it
// completes only once that register frees.
// After reset the bitmap is cleared one word per cycle, one word per 32
// reachable frames rounded up (128 words at defaults), with o_in_stall high.
module frame_bitmap_allocator #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fba_pkg::ACT_W-1:0]     i_action,
    input  logic [fba_pkg::FRAME_W-1:0]   i_page_frame,
    input  logic                          i_kernel_page,
    input  logic                          i_writable_page,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fba_pkg::STAT_W-1:0]    o_status,
    output logic [fba_pkg::FRAME_W-1:0]   o_new_frame,
    output logic                          o_present_bit,
    output logic                          o_rw_bit,
    output logic                          o_user_bit,
    output logic                          o_in_use
);

    import fba_pkg::*;

    localparam int MAX_FRAMES = 1 << FRAME_W;
    localparam int REACH      = (NUM_FRAMES < MAX_FRAMES) ? NUM_FRAMES : MAX_FRAMES;
    localparam int DEPTH      = (REACH + WORD_W - 1) / WORD_W;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W      = FRAME_W + 1;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_SCAN = 6'b000100,
        S_REL  = 6'b001000,
        S_QRY  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic [AW-1:0]        r_chk, n_chk;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_kern, n_kern;
    logic                 r_wr, n_wr;

    t_status              r_res_status, n_res_status;
    logic [FRAME_W-1:0]   r_res_frame, n_res_frame;
    logic                 r_res_present, n_res_present;
    logic                 r_res_rw, n_res_rw;
    logic                 r_res_user, n_res_user;
    logic                 r_res_in_use, n_res_in_use;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [FRAME_W-1:0]   r_out_frame, n_out_frame;
    logic                 r_out_present, n_out_present;
    logic                 r_out_rw, n_out_rw;
    logic                 r_out_user, n_out_user;
    logic                 r_out_in_use, n_out_in_use;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;

    logic                 out_free;
    logic                 in_range;
    logic [AW-1:0]        in_word;
    logic [BIT_W:0]       zero_hit;
    logic [CMP_W-1:0]     cand;

    fba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_range = ({1'b0, i_page_frame} < CMP_W'(REACH));
    assign in_word  = i_page_frame[AW+BIT_W-1:BIT_W];
    assign zero_hit = lowest_zero(ram_rdata);
    assign cand     = CMP_W'({r_chk, zero_hit[BIT_W-1:0]});

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_chk         = r_chk;
        n_bit         = r_bit;
        n_kern        = r_kern;
        n_wr          = r_wr;
        n_res_status  = r_res_status;
        n_res_frame   = r_res_frame;
        n_res_present = r_res_present;
        n_res_rw      = r_res_rw;
        n_res_user    = r_res_user;
        n_res_in_use  = r_res_in_use;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_frame   = r_out_frame;
        n_out_present = r_out_present;
        n_out_rw      = r_out_rw;
        n_out_user    = r_out_user;
        n_out_in_use  = r_out_in_use;
        ram_we        = 1'b0;
        ram_waddr     = r_chk;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = r_addr;

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kern        = i_kernel_page;
                    n_wr          = i_writable_page;
                    n_bit         = i_page_frame[BIT_W-1:0];
                    n_chk         = in_word;
                    n_res_status  = ST_DONE;
                    n_res_frame   = '0;
                    n_res_present = 1'b0;
                    n_res_rw      = 1'b0;
                    n_res_user    = 1'b0;
                    n_res_in_use  = 1'b0;
                    n_state       = S_FIN;
                    case (i_action)
                        ACT_ALLOC: begin
                            if (i_page_frame != '0) begin
                                n_res_status = ST_SKIP;
                                n_res_frame  = i_page_frame;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_chk     = '0;
                                n_addr    = AW'(1);
                                n_state   = S_SCAN;
                            end
                        end
                        ACT_RELEASE: begin
                            if (i_page_frame == '0) begin
                                n_res_status = ST_SKIP;
                            end else if (in_range) begin
                                ram_re    = 1'b1;
                                ram_raddr = in_word;
                                n_state   = S_REL;
                            end
                        end
                        ACT_QUERY: begin
                            if (in_range) begin
                                ram_re    = 1'b1;
                                ram_raddr = in_word;
                                n_state   = S_QRY;
                            end
                        end
                        default: begin
                            n_res_status = ST_SKIP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (zero_hit[BIT_W] && (cand < CMP_W'(REACH))) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_chk;
                    ram_wdata     = ram_rdata | (WORD_W'(1) << zero_hit[BIT_W-1:0]);
                    n_res_status  = ST_DONE;
                    n_res_frame   = FRAME_W'(cand);
                    n_res_present = 1'b1;
                    n_res_rw      = r_wr;
                    n_res_user    = !r_kern;
                    n_state       = S_FIN;
                end else if (zero_hit[BIT_W] || (r_chk == AW'(DEPTH - 1))) begin
                    // free bit past the last reachable frame, or no word left
                    n_res_status = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_chk     = r_addr;
                    n_addr    = r_addr + AW'(1);
                end
            end
            S_REL: begin
                ram_we    = 1'b1;
                ram_waddr = r_chk;
                ram_wdata = ram_rdata & ~(WORD_W'(1) << r_bit);
                n_state   = S_FIN;
            end
            S_QRY: begin
                n_res_in_use = ram_rdata[r_bit];
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_frame   = r_res_frame;
                    n_out_present = r_res_present;
                    n_out_rw      = r_res_rw;
                    n_out_user    = r_res_user;
                    n_out_in_use  = r_res_in_use;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk         <= n_chk;
        r_bit         <= n_bit;
        r_kern        <= n_kern;
        r_wr          <= n_wr;
        r_res_status  <= n_res_status;
        r_res_frame   <= n_res_frame;
        r_res_present <= n_res_present;
        r_res_rw      <= n_res_rw;
        r_res_user    <= n_res_user;
        r_res_in_use  <= n_res_in_use;
        r_out_status  <= n_out_status;
        r_out_frame   <= n_out_frame;
        r_out_present <= n_out_present;
        r_out_rw      <= n_out_rw;
        r_out_user    <= n_out_user;
        r_out_in_use  <= n_out_in_use;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_new_frame   = r_out_frame;
    assign o_present_bit = r_out_present;
    assign o_rw_bit      = r_out_rw;
    assign o_user_bit    = r_out_user;
    assign o_in_use      = r_out_in_use;

`ifndef NO_ASSERTIONS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("bitmap written while idle");

    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished request not moved to output");

    a_present_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_present |-> (r_out_status == ST_DONE) && !r_out_in_use)
        else $error("present bit on a response that is not a done allocate");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_chk <= AW'(DEPTH - 1)))
        else $error("scan past last bitmap word");
`endif

endmodule
